[hw/rtl/i2cm_pkg.sv]
// Shared types and phase tables for the I2C master bit engine.
// Command entry passed from front to back, phase record and phase decode functions.
// No dependencies.
package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_RSTART = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  // data: write byte, or the assembled read byte (MSB = first sample)
  // flag: write -> sampled ack bit, read -> SDA level of the master's ack bit
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       flag;
  } cmd_entry_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       smp;
    logic       last;
    logic [7:0] rd;
    logic       ack;
  } phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } back_state_t;

  // Line levels and marks of one phase, indexed by bit slot and sub-phase.
  function automatic phase_t i2cm_phase(cmd_entry_t e, logic [3:0] bit_idx, logic [1:0] sub);
    phase_t p;
    logic   b;
    p = '0;
    b = e.data[~bit_idx[2:0]];
    unique case (e.cmd)
      CMD_START: begin
        p.scl  = (sub != 2'd2);
        p.sda  = (sub == 2'd0);
        p.last = (sub == 2'd2);
      end
      CMD_RSTART: begin
        p.scl  = sub[1];
        p.sda  = (sub != 2'd3);
        p.last = (sub == 2'd3);
      end
      CMD_STOP: begin
        p.scl  = 1'b1;
        p.sda  = sub[0];
        p.last = sub[0];
      end
      CMD_WRITE: begin
        if (bit_idx[3]) begin
          // ack slot: release and sample, then clock low
          p.scl  = !sub[0];
          p.sda  = 1'b1;
          p.smp  = !sub[0];
          p.last = sub[0];
          p.ack  = sub[0] & e.flag;
        end else begin
          p.scl = (sub == 2'd0);
          p.sda = (sub != 2'd2) & b;
        end
      end
      CMD_READ: begin
        if (bit_idx == 4'd9) begin
          p.last = 1'b1;
          p.rd   = e.data;
        end else if (bit_idx == 4'd8) begin
          p.scl = (sub == 2'd0);
          p.sda = (sub != 2'd2) & e.flag;
        end else begin
          p.scl = !sub[0];
          p.sda = 1'b1;
          p.smp = !sub[0];
        end
      end
      default: p = '0;
    endcase
    return p;
  endfunction

  // Last sub-phase index of the current bit slot.
  function automatic logic [1:0] i2cm_sub_max(cmd_t cmd, logic [3:0] bit_idx);
    logic [1:0] m;
    m = 2'd0;
    unique case (cmd)
      CMD_START:  m = 2'd2;
      CMD_RSTART: m = 2'd3;
      CMD_STOP:   m = 2'd1;
      CMD_WRITE:  m = bit_idx[3] ? 2'd1 : 2'd2;
      CMD_READ: begin
        if (bit_idx == 4'd8)     m = 2'd2;
        else if (bit_idx[3])     m = 2'd0;
        else                     m = 2'd1;
      end
      default: m = 2'd0;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/i2c_master_bit_engine.sv]
// I2C master bit engine: turns bus commands into timed SCL/SDA line phases.
// Accepted items wait in the queue; the back end pops each into a command register
// and loads its phases into the output register, each once the phase_cycles hold
// timer has run out and the output register is free. An item takes 2 to 26 phases.
// Items are queued QUEUE_DEPTH deep; input stays ready while the queue has room.
// Reset: phase_cycles = 500, queue and output register empty. Depends on i2cm_pkg.
module i2c_master_bit_engine #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_phase_cycles,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic        in_send_ack,
  input  logic [8:0]  in_slave_sda,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_release,
  output logic        out_sda_release,
  output logic        out_sample_point,
  output logic        out_last_phase,
  output logic [7:0]  out_read_data,
  output logic        out_ack_bit
);
  import i2cm_pkg::*;

  localparam logic [15:0] PHASE_CYCLES_RST = 16'd500;

  logic [15:0] phase_cycles_r;
  logic        q_push, q_pop, q_full, q_empty;
  cmd_entry_t  q_entry, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_cycles_r <= PHASE_CYCLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      phase_cycles_r <= cfg_phase_cycles;
    end
  end

  i2cm_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .in_send_ack  (in_send_ack),
    .in_slave_sda (in_slave_sda),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  i2cm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .phase_cycles     (phase_cycles_r),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_release  (out_scl_release),
    .out_sda_release  (out_sda_release),
    .out_sample_point (out_sample_point),
    .out_last_phase   (out_last_phase),
    .out_read_data    (out_read_data),
    .out_ack_bit      (out_ack_bit)
  );

endmodule

[hw/rtl/i2cm_front.sv]
// Front end: accepts command items, drops unknown kinds and builds queue entries.
// Depends on i2cm_pkg.
module i2cm_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_kind,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_send_ack,
  input  logic [8:0]            in_slave_sda,
  input  logic                  q_full,
  output logic                  q_push,
  output i2cm_pkg::cmd_entry_t  q_entry
);
  import i2cm_pkg::*;

  logic       known;
  logic [7:0] rd_byte;

  // first sample lands in the MSB
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rd_byte[7 - i] = in_slave_sda[i];
    end
  end

  always_comb begin
    known         = 1'b1;
    q_entry.cmd   = cmd_t'(in_kind);
    q_entry.data  = 8'd0;
    q_entry.flag  = 1'b0;
    unique case (in_kind)
      CMD_START, CMD_RSTART, CMD_STOP: ;
      CMD_WRITE: begin
        q_entry.data = in_data_byte;
        q_entry.flag = in_slave_sda[0];
      end
      CMD_READ: begin
        q_entry.data = rd_byte;
        q_entry.flag = !in_send_ack;
      end
      default: known = 1'b0;
    endcase
  end

  assign in_ready = !q_full;
  // unknown kinds are taken and dropped
  assign q_push   = in_valid && in_ready && known;

endmodule

[hw/rtl/i2cm_queue.sv]
// Short command queue between the front end and the phase sequencer.
// Depends on i2cm_pkg.
module i2cm_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  i2cm_pkg::cmd_entry_t  push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output i2cm_pkg::cmd_entry_t  head
);
  import i2cm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_entry_t      mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_ptrs_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree while empty");

endmodule

[hw/rtl/i2cm_back.sv]
// Back end: walks each queued command's line phases into a registered output,
// as the hold timer and out_ready allow. Depends on i2cm_pkg.
module i2cm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           phase_cycles,
  input  logic                  q_empty,
  input  i2cm_pkg::cmd_entry_t  q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_scl_release,
  output logic                  out_sda_release,
  output logic                  out_sample_point,
  output logic                  out_last_phase,
  output logic [7:0]            out_read_data,
  output logic                  out_ack_bit
);
  import i2cm_pkg::*;

  back_state_t  state_r, state_nxt;
  cmd_entry_t   cur_r, cur_nxt;
  logic [3:0]   bit_idx_r, bit_idx_nxt;
  logic [1:0]   sub_r, sub_nxt;
  logic [15:0]  wait_r, wait_nxt;
  logic         out_valid_r, out_valid_nxt;
  phase_t       out_ph_r;
  phase_t       ph;
  logic         out_load;

  assign ph       = i2cm_phase(cur_r, bit_idx_r, sub_r);
  assign out_load = (state_r == ST_RUN) && (wait_r == '0) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    bit_idx_nxt   = bit_idx_r;
    sub_nxt       = sub_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cur_nxt     = q_head;
          bit_idx_nxt = '0;
          sub_nxt     = '0;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (ph.last) begin
            state_nxt = ST_IDLE;
          end else if (sub_r == i2cm_sub_max(cur_r.cmd, bit_idx_r)) begin
            bit_idx_nxt = bit_idx_r + 1'b1;
            sub_nxt     = '0;
          end else begin
            sub_nxt = sub_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // phase hold timer, runs across command boundaries
  always_comb begin
    wait_nxt = wait_r;
    if (out_load) begin
      wait_nxt = (phase_cycles == '0) ? '0 : phase_cycles - 1'b1;
    end else if (wait_r != '0) begin
      wait_nxt = wait_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
      bit_idx_r   <= '0;
      sub_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
      bit_idx_r   <= bit_idx_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (out_load) begin
      out_ph_r <= ph;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_release  = out_ph_r.scl;
  assign out_sda_release  = out_ph_r.sda;
  assign out_sample_point = out_ph_r.smp;
  assign out_last_phase   = out_ph_r.last;
  assign out_read_data    = out_ph_r.rd;
  assign out_ack_bit      = out_ph_r.ack;

  a_timer_gates_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (wait_r == '0))
    else $error("phase issued before hold time elapsed");

  a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ph.last) |=> (state_r == ST_IDLE))
    else $error("sequencer kept running after last phase");

  a_bit_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (bit_idx_r <= 4'd9))
    else $error("bit slot out of range");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("queue popped while a command is running");

endmodule
